### design/cdq_pkg.sv
package cdq_pkg;

   localparam int DEPTH  = 16;
   localparam int WIDTH  = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

   typedef enum logic [3:0] {
      FUNC_PUSH_FRONT = 4'd0,
      FUNC_POP_FRONT  = 4'd1,
      FUNC_PUSH_BACK  = 4'd2,
      FUNC_POP_BACK   = 4'd3,
      FUNC_READ_FRONT = 4'd4,
      FUNC_READ_BACK  = 4'd5,
      FUNC_READ_INDEX = 4'd6,
      FUNC_CLEAR      = 4'd7,
      FUNC_STATUS     = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2,
      ERR_RANGE     = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [3:0]        func;
      logic [WIDTH-1:0]  value;
      logic [ADDR_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [WIDTH-1:0] read_data;
      logic [1:0]       error_code;
      logic [CNT_W-1:0] count;
      logic             is_empty;
      logic             is_full;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_cfg;
   } cmd_type;

endpackage

### design/cdq_ctrl.sv
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  logic    csr_valid,
   output logic    csr_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      csr_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            // configuration takes precedence over a new item
            if (csr_valid) begin
               cmd.load_cfg = 1'b1;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/cdq_datapath.sv
module cdq_datapath
   import cdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req_data,
   input  logic [CNT_W-1:0] csr_data,
   output rsp_type          rsp_data
);

   logic [WIDTH-1:0]  mem [DEPTH];

   req_type           req_ff;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        err_ff, err_in;
   logic              sel_ff, sel_in;
   logic [WIDTH-1:0]  rd_data_ff;

   logic [CNT_W-1:0]  head_ext, tail_ext, pos_ext, idx_sum;
   logic [ADDR_W-1:0] head_inc, head_dec, tail_inc, tail_dec, idx;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              wr_en, rd_en, full, empty;

   // clamp the written capacity into 1..DEPTH
   always_comb begin
      if (csr_data == '0) begin
         cap_in = CNT_W'(1);
      end else if (csr_data > CNT_W'(DEPTH)) begin
         cap_in = CNT_W'(DEPTH);
      end else begin
         cap_in = csr_data;
      end
   end

   always_comb begin
      head_ext = {1'b0, head_ff};
      tail_ext = {1'b0, tail_ff};
      pos_ext  = {1'b0, req_ff.position};
      head_inc = (head_ext + CNT_W'(1) >= cap_ff) ? '0 : head_ff + ADDR_W'(1);
      tail_inc = (tail_ext + CNT_W'(1) >= cap_ff) ? '0 : tail_ff + ADDR_W'(1);
      head_dec = (head_ff == '0) ? ADDR_W'(cap_ff - CNT_W'(1)) : head_ff - ADDR_W'(1);
      tail_dec = (tail_ff == '0) ? ADDR_W'(cap_ff - CNT_W'(1)) : tail_ff - ADDR_W'(1);
      idx_sum  = head_ext + pos_ext;
      idx      = (idx_sum >= cap_ff) ? ADDR_W'(idx_sum - cap_ff) : ADDR_W'(idx_sum);
      full     = (count_ff >= cap_ff);
      empty    = (count_ff == '0);

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      err_in   = ERR_OK;
      sel_in   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;

      unique case (func_type'(req_ff.func))
         FUNC_PUSH_FRONT: begin
            if (full) begin
               err_in = ERR_OVERFLOW;
            end else begin
               head_in  = head_dec;
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_POP_FRONT: begin
            if (empty) begin
               err_in = ERR_UNDERFLOW;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               sel_in   = 1'b1;
               head_in  = head_inc;
               count_in = count_ff - CNT_W'(1);
            end
         end
         FUNC_PUSH_BACK: begin
            if (full) begin
               err_in = ERR_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               tail_in  = tail_inc;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_POP_BACK: begin
            if (empty) begin
               err_in = ERR_UNDERFLOW;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = tail_dec;
               sel_in   = 1'b1;
               tail_in  = tail_dec;
               count_in = count_ff - CNT_W'(1);
            end
         end
         FUNC_READ_FRONT: begin
            if (empty) begin
               err_in = ERR_UNDERFLOW;
            end else begin
               rd_en   = 1'b1;
               rd_addr = head_ff;
               sel_in  = 1'b1;
            end
         end
         FUNC_READ_BACK: begin
            if (empty) begin
               err_in = ERR_UNDERFLOW;
            end else begin
               rd_en   = 1'b1;
               rd_addr = tail_dec;
               sel_in  = 1'b1;
            end
         end
         FUNC_READ_INDEX: begin
            if (pos_ext >= count_ff) begin
               err_in = ERR_RANGE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx;
               sel_in  = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
            // status and unused codes: report only
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         err_ff   <= ERR_OK;
         sel_ff   <= 1'b0;
      end else if (cmd.load_cfg) begin
         cap_ff   <= cap_in;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         err_ff   <= err_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= req_ff.value;
      end
      if (cmd.exec && rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      rsp_data.read_data  = sel_ff ? rd_data_ff : '0;
      rsp_data.error_code = err_ff;
      rsp_data.count      = count_ff;
      rsp_data.is_empty   = (count_ff == '0);
      rsp_data.is_full    = (count_ff == cap_ff);
   end

endmodule

### design/circular_deque_core.sv
// Each accepted item passes the execute state, then the respond state, in which the
// result is held valid until rsp_ready takes it. One item is in flight at a time,
// set by the controller stepping each item through idle, execute and respond before
// it takes the next.
// Reset: empties the queue (pointers and count to zero) and sets capacity to 16;
// ring contents are not cleared. A capacity write also empties the queue.
module circular_deque_core
   import cdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data
);

   cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   cdq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

endmodule

### sim/circular_deque_core_test.sv
`timescale 1ns / 100ps

module circular_deque_core_test;
   import cdq_pkg::*;

   localparam int               LATENCY        = 3;
   localparam int               HOLD_CYCLES    = 250;
   localparam int               PHASES         = 12;
   localparam int               PHASE_ITEMS    = 148;
   localparam logic [3:0]       FUNC_UNUSED_LO = 4'd9;
   localparam logic [3:0]       FUNC_UNUSED_HI = 4'd15;

   class deque_scoreboard;
      logic [WIDTH-1:0] ring [DEPTH];
      int unsigned      head;
      int unsigned      tail;
      int unsigned      held;
      logic [CNT_W-1:0] cap_reg;
      rsp_type          expected_rsp [$];
      int unsigned      errors;
      int unsigned      items;
      int unsigned      err_hits [4];

      function new();
         cap_reg = CAP_RESET;
         head    = 0;
         tail    = 0;
         held    = 0;
         errors  = 0;
         items   = 0;
         foreach (err_hits[i]) err_hits[i] = 0;
      endfunction

      // zero acts as one entry, anything above the built depth as the depth
      function int unsigned limit();
         if (cap_reg == 0) return 1;
         if (cap_reg > DEPTH) return DEPTH;
         return cap_reg;
      endfunction

      function void write_capacity(logic [CNT_W-1:0] v);
         cap_reg = v;
         head    = 0;
         tail    = 0;
         held    = 0;
      endfunction

      function void apply_request(req_type r);
         rsp_type     want;
         int unsigned lim;
         int unsigned idx;
         lim = limit();
         want = '0;
         want.error_code = ERR_OK;
         items++;
         case (r.func)
            FUNC_PUSH_FRONT: begin
               if (held >= lim) begin
                  want.error_code = ERR_OVERFLOW;
               end else begin
                  head = (head == 0) ? lim - 1 : head - 1;
                  ring[head] = r.value;
                  held++;
               end
            end
            FUNC_POP_FRONT: begin
               if (held == 0) begin
                  want.error_code = ERR_UNDERFLOW;
               end else begin
                  want.read_data = ring[head];
                  head = (head + 1 >= lim) ? 0 : head + 1;
                  held--;
               end
            end
            FUNC_PUSH_BACK: begin
               if (held >= lim) begin
                  want.error_code = ERR_OVERFLOW;
               end else begin
                  ring[tail] = r.value;
                  tail = (tail + 1 >= lim) ? 0 : tail + 1;
                  held++;
               end
            end
            FUNC_POP_BACK: begin
               if (held == 0) begin
                  want.error_code = ERR_UNDERFLOW;
               end else begin
                  tail = (tail == 0) ? lim - 1 : tail - 1;
                  want.read_data = ring[tail];
                  held--;
               end
            end
            FUNC_READ_FRONT: begin
               if (held == 0) want.error_code = ERR_UNDERFLOW;
               else want.read_data = ring[head];
            end
            FUNC_READ_BACK: begin
               if (held == 0) want.error_code = ERR_UNDERFLOW;
               else want.read_data = ring[(tail == 0) ? lim - 1 : tail - 1];
            end
            FUNC_READ_INDEX: begin
               if (r.position >= held) begin
                  want.error_code = ERR_RANGE;
               end else begin
                  idx = head + r.position;
                  if (idx >= lim) idx -= lim;
                  want.read_data = ring[idx];
               end
            end
            FUNC_CLEAR: begin
               head = 0;
               tail = 0;
               held = 0;
            end
            default: ;
         endcase
         want.count    = CNT_W'(held);
         want.is_empty = (held == 0);
         want.is_full  = (held == lim);
         err_hits[want.error_code]++;
         expected_rsp.insert(expected_rsp.size(), want);
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("result %h arrived with no item outstanding", got);
            errors++;
            return;
         end
         want = expected_rsp[0];
         expected_rsp.delete(0);
         compare("read_data", want.read_data, got.read_data);
         compare("error_code", want.error_code, got.error_code);
         compare("count", want.count, got.count);
         compare("is_empty", want.is_empty, got.is_empty);
         compare("is_full", want.is_full, got.is_full);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data;

   deque_scoreboard  sb = new();
   int unsigned      send_idle_max = 15;
   int unsigned      recv_idle_max = 15;
   bit               hold_request  = 1'b0;
   int unsigned      cap_writes    = 0;

   circular_deque_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   task automatic send_item(req_type item);
      int unsigned gap;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.apply_request(item);
   endtask

   task automatic send_op(logic [3:0] func, logic [WIDTH-1:0] value, logic [ADDR_W-1:0] pos);
      req_type item;
      item.func     = func;
      item.value    = value;
      item.position = pos;
      send_item(item);
   endtask

   // drop valid and let every outstanding result drain
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CNT_W-1:0] v);
      drain();
      repeat (LATENCY + 2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_capacity(v);
      cap_writes++;
   endtask

   function automatic req_type random_request(int unsigned push_pct);
      req_type     r;
      int unsigned roll;
      r.value    = $urandom;
      r.position = ADDR_W'($urandom_range(0, DEPTH - 1));
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         r.func = FUNC_CLEAR;
      end else if (roll < 6) begin
         r.func = 4'($urandom_range(FUNC_STATUS, FUNC_UNUSED_HI));
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < push_pct) begin
            r.func = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
         end else if (roll < push_pct + (100 - push_pct) / 2) begin
            r.func = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
         end else begin
            case ($urandom_range(0, 2))
               0:       r.func = FUNC_READ_FRONT;
               1:       r.func = FUNC_READ_BACK;
               default: r.func = FUNC_READ_INDEX;
            endcase
         end
      end
      // aim most indexed reads at held positions
      if (r.func == FUNC_READ_INDEX && sb.held > 0 && $urandom_range(0, 3) != 0)
         r.position = ADDR_W'($urandom_range(0, sb.held - 1));
      return r;
   endfunction

   initial begin
      int unsigned gap;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
            gap = $urandom_range(0, recv_idle_max);
            if (hold_request) begin
               gap = HOLD_CYCLES;
               hold_request = 1'b0;
            end
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [CNT_W-1:0] cap_plan [10];
      int unsigned      push_pct;
      logic [CNT_W-1:0] cap;

      cap_plan = '{5'd31, 5'd1, 5'd2, 5'd16, 5'd0,
                   5'd17, 5'd3, 5'd8, 5'd16, 5'd5};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue at reset capacity
      send_op(FUNC_STATUS, '0, '0);
      send_op(FUNC_POP_FRONT, '0, '0);
      send_op(FUNC_POP_BACK, '0, '0);
      send_op(FUNC_READ_FRONT, '0, '0);
      send_op(FUNC_READ_BACK, '0, '0);
      send_op(FUNC_READ_INDEX, '0, '0);
      send_op(FUNC_PUSH_BACK, '0, '1);
      send_op(FUNC_PUSH_BACK, '1, '0);
      send_op(FUNC_PUSH_FRONT, 32'hA5A5_5A5A, '0);
      send_op(FUNC_READ_FRONT, '0, '0);
      send_op(FUNC_READ_BACK, '0, '0);
      send_op(FUNC_READ_INDEX, '0, 4'd2);
      send_op(FUNC_READ_INDEX, '0, '1);
      send_op(FUNC_POP_FRONT, '0, '0);
      send_op(FUNC_POP_BACK, '0, '0);
      send_op(FUNC_UNUSED_LO, '1, '1);
      send_op(FUNC_UNUSED_HI, '0, '0);
      send_op(FUNC_CLEAR, '0, '0);

      // capacity zero behaves as a single entry
      write_capacity('0);
      send_op(FUNC_PUSH_FRONT, $urandom, '0);
      send_op(FUNC_PUSH_BACK, $urandom, '0);
      send_op(FUNC_READ_INDEX, '0, '0);
      send_op(FUNC_POP_BACK, '0, '0);
      send_op(FUNC_PUSH_BACK, $urandom, '0);
      send_op(FUNC_POP_FRONT, '0, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         cap = (phase < 10) ? cap_plan[phase] : CNT_W'($urandom_range(0, 31));
         write_capacity(cap);
         push_pct      = (phase % 3 == 2) ? 35 : ((phase % 3 == 0) ? 70 : 50);
         send_idle_max = (phase % 3 == 1) ? 0 : 15;
         recv_idle_max = (phase % 4 == 1) ? 0 : 15;
         if (phase == 3) begin
            send_idle_max = 0;
            hold_request  = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_item(random_request(push_pct));
      end

      drain();
      repeat (LATENCY + 5) @(posedge clock);
      $display("Ran %0d operations across %0d capacity settings, including one long result stall",
               sb.items, cap_writes);
      $display("Error results seen: %0d overflow, %0d underflow, %0d out of range",
               sb.err_hits[ERR_OVERFLOW], sb.err_hits[ERR_UNDERFLOW], sb.err_hits[ERR_RANGE]);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
